/* rtl/rational_dot_product_accumulator_defines.svh */
// Assertion macros for the rational dot-product accumulator
`ifndef RATIONAL_DOT_PRODUCT_ACCUMULATOR_DEFINES_SVH
`define RATIONAL_DOT_PRODUCT_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define RDPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RDPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rdpa_pkg.sv */
// Shared widths and codes for the rational dot-product accumulator
`timescale 1ns / 1ps
package rdpa_pkg;
  localparam int OPW    = 16;
  localparam int ACCW   = 32;
  localparam int WIDEW  = 64;
  localparam int DATAW  = 64;
  localparam int OUTDW  = 64;

  typedef logic [WIDEW-1:0] wide_t;
  typedef logic [1:0]       err_t;

  localparam err_t ERR_NONE = 2'd0;
  localparam err_t ERR_ZDEN = 2'd1;
  localparam err_t ERR_OVF  = 2'd2;
endpackage

/* rtl/rational_dot_product_accumulator.sv */
// A word with a zero denominator skips from the check to the finish state; other words
// go through two rdpa_reduce passes, each a binary gcd (on the product, then on the sum)
// followed by bit-serial restoring division of numerator and denominator by the gcd.
// Throughput: one input word at a time; in_tready is high only while idle.
// The output register holds a result while the next word is taken; a last word waits
// while it is full. Synchronous active-low reset clears the sum to 0/1, the error, valid.
`timescale 1ns / 1ps
`include "rational_dot_product_accumulator_defines.svh"
module rational_dot_product_accumulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // a_num, a_den, b_num, b_den
  input  logic        in_tlast,  // last_term
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // result_num, result_den, zero pad
  output logic [1:0]  out_tuser  // error_code
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_MPN   = 4'd2;
  localparam logic [3:0] S_MPD   = 4'd3;
  localparam logic [3:0] S_RED1S = 4'd4;
  localparam logic [3:0] S_RED1W = 4'd5;
  localparam logic [3:0] S_MT1   = 4'd6;
  localparam logic [3:0] S_MT2   = 4'd7;
  localparam logic [3:0] S_MND   = 4'd8;
  localparam logic [3:0] S_ADD   = 4'd9;
  localparam logic [3:0] S_RED2S = 4'd10;
  localparam logic [3:0] S_RED2W = 4'd11;
  localparam logic [3:0] S_FIT   = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  logic [3:0]     state_r;
  logic [15:0]    an_r, ad_r, bn_r, bd_r;
  logic           last_r;
  logic           pneg_r, nneg_r;
  logic [31:0]    pm_r, pd_r;
  rdpa_pkg::wide_t t1_r, t2_r, nm_r, nd_r;
  logic [31:0]    sum_num_r;
  logic [30:0]    sum_den_r;
  rdpa_pkg::err_t err_r;
  logic           out_valid_r;
  logic [31:0]    out_num_r;
  logic [30:0]    out_den_r;
  rdpa_pkg::err_t out_err_r;

  logic [31:0]    mul_a, mul_b, sm;
  rdpa_pkg::wide_t mul_p, red_x, red_y, red_qx, red_qy;
  logic           red_start, red_done, sneg, nm_fits, nd_fits, out_load;

  function automatic logic [15:0] mag16(input logic [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

  assign sneg = sum_num_r[31];
  assign sm   = sneg ? (~sum_num_r + 32'd1) : sum_num_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MPN: begin
        mul_a = {16'd0, mag16(an_r)};
        mul_b = {16'd0, mag16(bn_r)};
      end
      S_MPD: begin
        mul_a = {16'd0, mag16(ad_r)};
        mul_b = {16'd0, mag16(bd_r)};
      end
      S_MT1: begin
        mul_a = sm;
        mul_b = pd_r;
      end
      S_MT2: begin
        mul_a = pm_r;
        mul_b = {1'b0, sum_den_r};
      end
      S_MND: begin
        mul_a = {1'b0, sum_den_r};
        mul_b = pd_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = rdpa_pkg::wide_t'(mul_a) * rdpa_pkg::wide_t'(mul_b);

  assign red_start = (state_r == S_RED1S) || (state_r == S_RED2S);
  assign red_x     = (state_r == S_RED1S) ? {32'd0, pm_r} : nm_r;
  assign red_y     = (state_r == S_RED1S) ? {32'd0, pd_r} : nd_r;

  rdpa_reduce u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .start (red_start),
    .x     (red_x),
    .y     (red_y),
    .done  (red_done),
    .qx    (red_qx),
    .qy    (red_qy)
  );

  assign nd_fits = (nd_r[63:31] == '0);
  assign nm_fits = nneg_r ? ((nm_r[63:32] == '0) && (!nm_r[31] || nm_r[30:0] == '0))
                          : (nm_r[63:31] == '0);

  assign out_load = (state_r == S_FIN) && last_r && (!out_valid_r || out_tready);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_den_r, out_num_r};
  assign out_tuser  = out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_num_r   <= '0;
      sum_den_r   <= 31'd1;
      err_r       <= rdpa_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            an_r   <= in_tdata[15:0];
            ad_r   <= in_tdata[31:16];
            bn_r   <= in_tdata[47:32];
            bd_r   <= in_tdata[63:48];
            last_r <= in_tlast;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          pneg_r <= an_r[15] ^ ad_r[15] ^ bn_r[15] ^ bd_r[15];
          if (ad_r == '0 || bd_r == '0) begin
            if (err_r == rdpa_pkg::ERR_NONE) begin
              err_r <= rdpa_pkg::ERR_ZDEN;
            end
            state_r <= S_FIN;
          end else begin
            state_r <= S_MPN;
          end
        end
        S_MPN: begin
          pm_r <= mul_p[31:0];
          state_r <= S_MPD;
        end
        S_MPD: begin
          pd_r <= mul_p[31:0];
          state_r <= S_RED1S;
        end
        S_RED1S: begin
          state_r <= S_RED1W;
        end
        S_RED1W: begin
          if (red_done) begin
            pm_r <= red_qx[31:0];
            pd_r <= red_qy[31:0];
            if (red_qx == '0) begin
              pneg_r <= 1'b0;
            end
            state_r <= S_MT1;
          end
        end
        S_MT1: begin
          t1_r <= mul_p;
          state_r <= S_MT2;
        end
        S_MT2: begin
          t2_r <= mul_p;
          state_r <= S_MND;
        end
        S_MND: begin
          nd_r <= mul_p;
          state_r <= S_ADD;
        end
        S_ADD: begin
          if (sneg == pneg_r) begin
            nm_r   <= t1_r + t2_r;
            nneg_r <= sneg;
          end else if (t1_r >= t2_r) begin
            nm_r   <= t1_r - t2_r;
            nneg_r <= sneg;
          end else begin
            nm_r   <= t2_r - t1_r;
            nneg_r <= pneg_r;
          end
          state_r <= S_RED2S;
        end
        S_RED2S: begin
          state_r <= S_RED2W;
        end
        S_RED2W: begin
          if (red_done) begin
            nm_r <= red_qx;
            nd_r <= red_qy;
            if (red_qx == '0) begin
              nneg_r <= 1'b0;
            end
            state_r <= S_FIT;
          end
        end
        S_FIT: begin
          if (nm_fits && nd_fits) begin
            sum_num_r <= nneg_r ? (~nm_r[31:0] + 32'd1) : nm_r[31:0];
            sum_den_r <= nd_r[30:0];
          end else if (err_r == rdpa_pkg::ERR_NONE) begin
            err_r <= rdpa_pkg::ERR_OVF;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!last_r) begin
            state_r <= S_IDLE;
          end else if (out_load) begin
            out_err_r   <= err_r;
            out_num_r   <= (err_r == rdpa_pkg::ERR_NONE) ? sum_num_r : 32'd0;
            out_den_r   <= (err_r == rdpa_pkg::ERR_NONE) ? sum_den_r : 31'd1;
            sum_num_r   <= '0;
            sum_den_r   <= 31'd1;
            err_r       <= rdpa_pkg::ERR_NONE;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `RDPA_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready, "ready after take")
  `RDPA_ASSERT_NOW(a_err_zero_one, out_tvalid && out_tuser != rdpa_pkg::ERR_NONE,
    out_tdata[31:0] == 32'd0 && out_tdata[62:32] == 31'd1, "error word not 0/1")
  `RDPA_ASSERT_NOW(a_den_nonzero, out_tvalid, out_tdata[62:32] != 31'd0, "zero denominator out")
  `RDPA_ASSERT_NOW(a_sum_den_nonzero, state_r == S_IDLE, sum_den_r != 31'd0, "sum denominator 0")
endmodule

/* rtl/rdpa_reduce.sv */
// Binary gcd and restoring divider: reduce x/y to lowest terms
`timescale 1ns / 1ps
module rdpa_reduce (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  rdpa_pkg::wide_t x,
  input  rdpa_pkg::wide_t y,
  output logic           done,
  output rdpa_pkg::wide_t qx,
  output rdpa_pkg::wide_t qy
);
  localparam logic [2:0] R_IDLE = 3'd0;
  localparam logic [2:0] R_GCD0 = 3'd1;
  localparam logic [2:0] R_GLP  = 3'd2;
  localparam logic [2:0] R_DIVX = 3'd3;
  localparam logic [2:0] R_DIVY = 3'd4;
  localparam logic [2:0] R_DONE = 3'd5;

  logic [2:0]      state_r;
  rdpa_pkg::wide_t u_r, v_r, x_r, y_r, g_r, rem_r, quo_r, qx_r;
  logic [5:0]      k_r, cnt_r;
  logic [64:0]     rem_sh;
  logic [64:0]     rem_sub;
  logic            fit;

  assign rem_sh  = {rem_r, quo_r[63]};
  assign rem_sub = rem_sh - {1'b0, g_r};
  assign fit     = !rem_sub[64];

  assign done = (state_r == R_DONE);
  assign qx   = qx_r;
  assign qy   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
    end else begin
      unique case (state_r)
        R_IDLE: begin
          if (start) begin
            x_r <= x;
            y_r <= y;
            u_r <= x;
            v_r <= y;
            k_r <= '0;
            state_r <= R_GCD0;
          end
        end
        R_GCD0: begin
          if (u_r == '0 || v_r == '0) begin
            g_r   <= ((u_r | v_r) == '0) ? rdpa_pkg::wide_t'(1) : (u_r | v_r);
            rem_r <= '0;
            quo_r <= x_r;
            cnt_r <= '0;
            state_r <= R_DIVX;
          end else if (!u_r[0] && !v_r[0]) begin
            u_r <= u_r >> 1;
            v_r <= v_r >> 1;
            k_r <= k_r + 6'd1;
          end else begin
            state_r <= R_GLP;
          end
        end
        R_GLP: begin
          if (u_r == '0) begin
            g_r   <= v_r << k_r;
            rem_r <= '0;
            quo_r <= x_r;
            cnt_r <= '0;
            state_r <= R_DIVX;
          end else if (!u_r[0]) begin
            u_r <= u_r >> 1;
          end else if (!v_r[0]) begin
            v_r <= v_r >> 1;
          end else if (u_r >= v_r) begin
            u_r <= u_r - v_r;
          end else begin
            v_r <= v_r - u_r;
          end
        end
        R_DIVX, R_DIVY: begin
          rem_r <= fit ? rem_sub[63:0] : rem_sh[63:0];
          quo_r <= {quo_r[62:0], fit};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            if (state_r == R_DIVX) begin
              qx_r  <= {quo_r[62:0], fit};
              rem_r <= '0;
              quo_r <= y_r;
              state_r <= R_DIVY;
            end else begin
              state_r <= R_DONE;
            end
          end
        end
        R_DONE: begin
          state_r <= R_IDLE;
        end
        default: begin
          state_r <= R_IDLE;
        end
      endcase
    end
  end
endmodule
